FILE: design/swsd_pkg.sv
// Package for the sliding-window standard deviation core.
// Holds the sample and result widths, the sequencer state types and the
// status struct of the divide / square-root engine. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package swsd_pkg;

  // Field widths
  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned STD_W    = 24;
  localparam int unsigned FILL_W   = 7;

  // Default window depth
  localparam int unsigned DEF_WINDOW_LEN = 64;

  // Fixed-point: variance carries FRAC_W fraction bits and always fits VAR_W bits
  localparam int unsigned FRAC_W   = 16;
  localparam int unsigned VAR_W    = 48;
  localparam int unsigned HI_SHIFT = VAR_W - FRAC_W;
  localparam int unsigned ROOT_W   = VAR_W / 2;
  localparam int unsigned STEP_W   = $clog2(VAR_W);

  // Main sequencer
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_SQ_NEW,
    ST_SQ_OLD,
    ST_MUL_NS,
    ST_MUL_SQ,
    ST_MUL_DEN,
    ST_START,
    ST_CALC,
    ST_OUT
  } sw_state_e;

  // Divide / square-root engine
  typedef enum logic [1:0] {
    IT_IDLE,
    IT_DIV,
    IT_SQRT
  } iter_state_e;

  typedef struct packed {
    logic busy;
    logic done;
  } iter_stat_t;

endpackage

`default_nettype wire

FILE: design/swsd_iter.sv
// Iterative divide and square-root engine around one shared subtractor.
// Divides num * 2^FRAC_W by den one quotient bit a cycle, then takes the
// floored square root two radicand bits a cycle. Depends on swsd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module swsd_iter
  import swsd_pkg::*;
#(
  parameter int unsigned CNT_W = 7
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                start_i,
  input  wire logic [2*SAMPLE_W-2+2*CNT_W-1:0]     num_i,
  input  wire logic [2*CNT_W-1:0]                  den_i,
  output iter_stat_t                               stat_o,
  output logic [ROOT_W-1:0]                        root_o
);

  localparam int unsigned DEN_W = 2 * CNT_W;
  localparam int unsigned U_W   = (DEN_W + 1 > ROOT_W + 2) ? DEN_W + 1 : ROOT_W + 2;

  iter_state_e state_q, state_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [U_W-1:0]    rem_q, rem_d;
  logic [VAR_W-1:0]  work_q, work_d;
  logic [ROOT_W-1:0] root_q, root_d;
  logic              done_q, done_d;

  logic [U_W-1:0]    trial;
  logic [U_W-1:0]    subtrahend;
  logic [U_W:0]      diff;
  logic              fits;
  logic              div_last, sqrt_last;

  // Shared subtractor: restoring step for both division and square root
  always_comb begin
    if (state_q == IT_SQRT) begin
      trial      = {rem_q[U_W-3:0], work_q[VAR_W-1 -: 2]};
      subtrahend = U_W'({root_q, 2'b01});
    end else begin
      trial      = {rem_q[U_W-2:0], work_q[VAR_W-1]};
      subtrahend = U_W'(den_i);
    end
    diff = {1'b0, trial} - {1'b0, subtrahend};
    fits = ~diff[U_W];
  end

  assign div_last  = (step_q == STEP_W'(VAR_W - 1));
  assign sqrt_last = (step_q == STEP_W'(ROOT_W - 1));

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      IT_IDLE: if (start_i)   state_d = IT_DIV;
      IT_DIV:  if (div_last)  state_d = IT_SQRT;
      IT_SQRT: if (sqrt_last) state_d = IT_IDLE;
      default:                state_d = IT_IDLE;
    endcase
  end

  // Datapath updates
  always_comb begin
    step_d = step_q;
    rem_d  = rem_q;
    work_d = work_q;
    root_d = root_q;
    done_d = 1'b0;
    unique case (state_q)
      IT_IDLE: begin
        if (start_i) begin
          // high part is below den since the quotient fits VAR_W bits
          rem_d  = U_W'(num_i >> HI_SHIFT);
          work_d = {num_i[HI_SHIFT-1:0], {FRAC_W{1'b0}}};
          step_d = '0;
        end
      end
      IT_DIV: begin
        rem_d  = fits ? diff[U_W-1:0] : trial;
        work_d = {work_q[VAR_W-2:0], fits};
        if (div_last) begin
          // quotient now in work_q: becomes the radicand
          rem_d  = '0;
          root_d = '0;
          step_d = '0;
        end else begin
          step_d = step_q + STEP_W'(1);
        end
      end
      IT_SQRT: begin
        rem_d  = fits ? diff[U_W-1:0] : trial;
        work_d = {work_q[VAR_W-3:0], 2'b00};
        root_d = {root_q[ROOT_W-2:0], fits};
        step_d = step_q + STEP_W'(1);
        done_d = sqrt_last;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= IT_IDLE;
      done_q  <= 1'b0;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
      step_q  <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    work_q <= work_d;
    root_q <= root_d;
  end

  assign stat_o.busy = (state_q != IT_IDLE);
  assign stat_o.done = done_q;
  assign root_o      = root_q;

endmodule

`default_nettype wire

FILE: design/sliding_window_std_dev_core.sv
// Top level of the sliding-window sample standard deviation core.
// Keeps the sample ring, running sums and a shared multiplier under a small
// sequencer; uses swsd_pkg and the divide / square-root engine swsd_iter.
//
//  channel   | dir | handshake                      | payload
//  ----------+-----+--------------------------------+------------------------------------
//  s_axis    | in  | s_axis_tvalid / s_axis_tready  | tdata[15:0] sample (signed)
//  m_axis    | out | m_axis_tvalid / m_axis_tready  | tdata[23:0] std_dev, [30:24] fill_count
//
//  From input transfer to the earliest result transfer an item passes seven sequencer
//  steps (five of them on the shared multiplier), 48 divide and 24 square-root steps on
//  the shared subtractor in swsd_iter, a hand-over step and the output load.
//  With a single sample held the sequencer skips to the output load after the squares.
//  s_axis_tready is high only while the sequencer is idle; a result waiting in the
//  output register does not hold off the next input transfer.
//  Reset clears the counts and sums; the ring needs no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module sliding_window_std_dev_core
  import swsd_pkg::*;
#(
  parameter int unsigned WINDOW_LEN = DEF_WINDOW_LEN
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,   // [15:0] sample
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata    // [23:0] std_dev, [30:24] fill_count, [31] zero
);

  localparam int unsigned CNT_W  = $clog2(WINDOW_LEN + 1);
  localparam int unsigned SLOT_W = $clog2(WINDOW_LEN);
  localparam int unsigned SUM_W  = SAMPLE_W + CNT_W;
  localparam int unsigned SQ_W   = 2 * SAMPLE_W - 2 + CNT_W;
  localparam int unsigned NUM_W  = SQ_W + CNT_W;
  localparam int unsigned DEN_W  = 2 * CNT_W;
  localparam int unsigned A_W    = SQ_W;
  localparam int unsigned B_W    = SUM_W;
  localparam int unsigned P_W    = A_W + B_W;

  sw_state_e state_q, state_d;

  // Sequencer controls
  logic              accept;
  logic              ring_we;
  logic              iter_start;
  logic              out_load;
  logic [A_W-1:0]    mul_a;
  logic [B_W-1:0]    mul_b;

  // State and datapath registers
  logic [SAMPLE_W-1:0]    ring_mem [WINDOW_LEN];
  logic [SAMPLE_W-1:0]    ring_rd_q;
  logic [SLOT_W-1:0]      slot_q;
  logic [CNT_W-1:0]       held_q;
  logic                   full_q;
  logic signed [SUM_W-1:0] sum_q;
  logic [SQ_W-1:0]        sumsq_q;
  logic [SAMPLE_W-1:0]    sample_q;
  logic [SAMPLE_W-1:0]    old_mag_q;
  logic [P_W-1:0]         mul_q;
  logic [NUM_W-1:0]       ns_q;
  logic [NUM_W-1:0]       num_q;
  logic [DEN_W-1:0]       den_q;
  logic                   m_valid_q;
  logic [STD_W-1:0]       std_q;
  logic [FILL_W-1:0]      fill_q;

  logic [SAMPLE_W-1:0]    old_val;
  logic [SAMPLE_W-1:0]    new_mag;
  logic [SUM_W-1:0]       sum_mag;
  logic                   few_held;
  iter_stat_t             iter_stat;
  logic [ROOT_W-1:0]      iter_root;

  assign accept   = s_axis_tvalid & s_axis_tready;
  assign few_held = (held_q < CNT_W'(2));

  // Oldest sample leaves only once the window is full
  assign old_val = full_q ? ring_rd_q : '0;
  assign new_mag = sample_q[SAMPLE_W-1] ? (~sample_q + SAMPLE_W'(1)) : sample_q;
  assign sum_mag = sum_q[SUM_W-1] ? SUM_W'(-sum_q) : SUM_W'(sum_q);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:    if (accept) state_d = ST_LOAD;
      ST_LOAD:    state_d = ST_SQ_NEW;
      ST_SQ_NEW:  state_d = ST_SQ_OLD;
      ST_SQ_OLD:  state_d = few_held ? ST_OUT : ST_MUL_NS;
      ST_MUL_NS:  state_d = ST_MUL_SQ;
      ST_MUL_SQ:  state_d = ST_MUL_DEN;
      ST_MUL_DEN: state_d = ST_START;
      ST_START:   state_d = ST_CALC;
      ST_CALC:    if (iter_stat.done) state_d = ST_OUT;
      ST_OUT:     if (!m_valid_q || m_axis_tready) state_d = ST_IDLE;
      default:    state_d = ST_IDLE;
    endcase
  end

  // Sequencer outputs and multiplier operand select
  always_comb begin
    s_axis_tready = 1'b0;
    ring_we       = 1'b0;
    iter_start    = 1'b0;
    out_load      = 1'b0;
    mul_a         = '0;
    mul_b         = '0;
    unique case (state_q)
      ST_IDLE:    s_axis_tready = 1'b1;
      ST_LOAD: begin
        ring_we = 1'b1;
        mul_a   = A_W'(new_mag);
        mul_b   = B_W'(new_mag);
      end
      ST_SQ_NEW: begin
        mul_a = A_W'(old_mag_q);
        mul_b = B_W'(old_mag_q);
      end
      ST_MUL_NS: begin
        mul_a = sumsq_q;
        mul_b = B_W'(held_q);
      end
      ST_MUL_SQ: begin
        mul_a = A_W'(sum_mag);
        mul_b = sum_mag;
      end
      ST_MUL_DEN: begin
        mul_a = A_W'(held_q);
        mul_b = B_W'(held_q - CNT_W'(1));
      end
      ST_START:   iter_start = 1'b1;
      ST_OUT:     out_load = !m_valid_q || m_axis_tready;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Sample ring: written once per item, read every cycle at the write slot
  always_ff @(posedge clk_i) begin
    if (ring_we) begin
      ring_mem[slot_q] <= sample_q;
    end
    ring_rd_q <= ring_mem[slot_q];
  end

  // Window bookkeeping and running sums
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q  <= '0;
      held_q  <= '0;
      full_q  <= 1'b0;
      sum_q   <= '0;
      sumsq_q <= '0;
    end else begin
      if (accept) begin
        full_q <= (held_q == CNT_W'(WINDOW_LEN));
        if (held_q != CNT_W'(WINDOW_LEN)) begin
          held_q <= held_q + CNT_W'(1);
        end
      end
      if (ring_we) begin
        slot_q <= (slot_q == SLOT_W'(WINDOW_LEN - 1)) ? '0 : slot_q + SLOT_W'(1);
        sum_q  <= sum_q
                  + {{(SUM_W-SAMPLE_W){sample_q[SAMPLE_W-1]}}, sample_q}
                  - {{(SUM_W-SAMPLE_W){old_val[SAMPLE_W-1]}}, old_val};
      end
      if (state_q == ST_SQ_NEW) begin
        sumsq_q <= sumsq_q + mul_q[SQ_W-1:0];
      end
      if (state_q == ST_SQ_OLD) begin
        sumsq_q <= sumsq_q - mul_q[SQ_W-1:0];
      end
    end
  end

  // Shared multiplier and the terms of the variance
  always_ff @(posedge clk_i) begin
    mul_q <= P_W'(mul_a) * P_W'(mul_b);
    if (accept) begin
      sample_q <= s_axis_tdata;
    end
    if (ring_we) begin
      old_mag_q <= old_val[SAMPLE_W-1] ? (~old_val + SAMPLE_W'(1)) : old_val;
    end
    if (state_q == ST_MUL_SQ) begin
      ns_q <= mul_q[NUM_W-1:0];
    end
    if (state_q == ST_MUL_DEN) begin
      num_q <= (ns_q >= mul_q[NUM_W-1:0]) ? ns_q - mul_q[NUM_W-1:0] : '0;
    end
    if (state_q == ST_START) begin
      den_q <= mul_q[DEN_W-1:0];
    end
  end

  swsd_iter #(
    .CNT_W (CNT_W)
  ) u_iter (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (iter_start),
    .num_i   (num_q),
    .den_i   (den_q),
    .stat_o  (iter_stat),
    .root_o  (iter_root)
  );

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (out_load) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      std_q  <= few_held ? '0 : STD_W'(iter_root);
      fill_q <= FILL_W'(held_q);
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {1'b0, fill_q, std_q};

endmodule

`default_nettype wire

FILE: design/swsd_chk.sv
// Port-level checker for sliding_window_std_dev_core, bound to the top level.
// Watches the two stream channels only. Depends on the top level's ports.
`timescale 1ns / 1ps
`default_nettype none

module swsd_chk (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [31:0] m_axis_tdata
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // One item at a time: busy right after an input transfer
  a_busy_after_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken while an item is in work");

  // A new result only appears out of a busy period
  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> !$past(s_axis_tready))
    else $error("result appeared without work");

  // Returning to idle always leaves a result behind
  a_idle_with_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(s_axis_tready) |-> m_axis_tvalid)
    else $error("item finished without a result");

endmodule

bind sliding_window_std_dev_core swsd_chk u_swsd_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
